>>> rtl/cpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared types and widths for the closest point pairs block.
// ----------------------------------------------------------------------------
package cpp_pkg;

   localparam int KEY_W  = 32;
   localparam int DIST_W = 34;
   localparam int SQ_W   = 33;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [15:0]  first_x;
      logic signed [15:0]  first_y;
      logic signed [15:0]  second_x;
      logic signed [15:0]  second_y;
      logic [DIST_W-1:0]   squared_distance;
      logic                final_res;
      logic [1:0]          status;
   } rsp_type;

   // order keys of a point pair, a <= b
   typedef struct packed {
      logic [KEY_W-1:0] a;
      logic [KEY_W-1:0] b;
   } pair_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FEW       = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
   localparam logic [1:0] STATUS_DROPPED   = 2'd3;

endpackage

>>> rtl/closest_point_pairs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_point_pairs
// Keeps points sorted by (x, y); on the last point reports the closest pairs, up to MAX_PAIRS.
// ----------------------------------------------------------------------------
// Insert: the store is walked down from the top, each larger key shifting up one place,
// and the new key is written into the gap. On the last point a minimum pass over all
// pairs finds the least distance, a pair pass collects the pairs at it, then results go out.
// Only one transaction is in work at a time; req_stall is high while busy.
// Reset (synchronous) empties the set; the point store itself is not cleared.
module closest_point_pairs #(
   parameter int MAX_POINTS = 256,
   parameter int MAX_PAIRS  = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cpp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cpp_pkg::rsp_type rsp_data
);

   localparam int PW  = $clog2(MAX_POINTS);
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int RAW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int NW  = $clog2(MAX_PAIRS + 1);
   localparam int KW  = cpp_pkg::KEY_W;
   localparam int DW  = cpp_pkg::DIST_W;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_INS_RD   = 4'd1;
   localparam logic [3:0] ST_INS_CMP  = 4'd2;
   localparam logic [3:0] ST_INS_PUT  = 4'd3;
   localparam logic [3:0] ST_CHECK    = 4'd4;
   localparam logic [3:0] ST_MIN      = 4'd5;
   localparam logic [3:0] ST_EMIT     = 4'd6;
   localparam logic [3:0] ST_OUT_RD   = 4'd7;
   localparam logic [3:0] ST_OUT_LD   = 4'd8;
   localparam logic [3:0] ST_OUT_WAIT = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [KW-1:0]     key_ff, key_in;
   logic              last_ff, last_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [CW-1:0]     i_ff, i_in, j_ff, j_in;
   logic [DW-1:0]     best_ff, best_in;
   logic              dropped_ff, dropped_in;
   logic              trunc_ff, trunc_in;
   logic [NW-1:0]     n_ff, n_in, k_ff, k_in;
   logic              have_prev_ff, have_prev_in;
   cpp_pkg::pair_type prev_ff, prev_in;
   logic              v1_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   cpp_pkg::rsp_type  rsp_ff, rsp_in;

   logic              mem_we;
   logic [PW-1:0]     mem_waddr, mem_rb;
   logic [KW-1:0]     mem_wdata, mem_qa, mem_qb;
   logic              ins_gt;
   logic              issue_more, iss, pipe_busy;
   logic              dist_valid;
   cpp_pkg::pair_type dist_pair, buf_q, pair_in;
   logic [DW-1:0]     pair_dist;
   logic              hit, dup, buf_we;
   logic [1:0]        set_status;

   cpp_point_mem #(.DEPTH(MAX_POINTS), .AW(PW)) u_mem (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .ra_addr (i_ff[PW-1:0]),
      .rb_addr (mem_rb),
      .qa      (mem_qa),
      .qb      (mem_qb)
   );

   assign pair_in.a = mem_qa;
   assign pair_in.b = mem_qb;

   cpp_dist_unit u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .in_pair   (pair_in),
      .out_valid (dist_valid),
      .out_pair  (dist_pair),
      .out_dist  (pair_dist)
   );

   cpp_result_buf #(.DEPTH(MAX_PAIRS), .AW(RAW)) u_buf (
      .clock (clock),
      .we    (buf_we),
      .waddr (n_ff[RAW-1:0]),
      .wdata (dist_pair),
      .raddr (k_ff[RAW-1:0]),
      .q     (buf_q)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign ins_gt     = mem_qb > key_ff;
   assign issue_more = ({1'b0, i_ff} + {{CW{1'b0}}, 1'b1}) < {1'b0, count_ff};
   assign iss        = ((state_ff == ST_MIN) || (state_ff == ST_EMIT && !trunc_ff))
                       && issue_more;
   assign pipe_busy  = v1_ff | dist_valid;
   assign hit        = dist_valid && (pair_dist == best_ff);
   assign dup        = have_prev_ff && (dist_pair == prev_ff);
   assign buf_we     = (state_ff == ST_EMIT) && hit && !dup && !trunc_ff
                       && (n_ff != NW'(MAX_PAIRS));
   assign set_status = dropped_ff ? cpp_pkg::STATUS_DROPPED :
                       (trunc_ff ? cpp_pkg::STATUS_TRUNCATED : cpp_pkg::STATUS_OK);

   always_comb begin
      mem_rb = j_ff[PW-1:0];
      if (state_ff == ST_INS_RD) begin
         mem_rb = PW'(pos_ff - CW'(1));
      end else if (state_ff == ST_INS_CMP) begin
         mem_rb = PW'(pos_ff - CW'(2));
      end
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      best_in      = best_ff;
      dropped_in   = dropped_ff;
      trunc_in     = trunc_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      have_prev_in = have_prev_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff[PW-1:0];
      mem_wdata    = key_ff;

      if (iss) begin
         if (j_ff + CW'(1) == count_ff) begin
            i_in = i_ff + CW'(1);
            j_in = i_ff + CW'(2);
         end else begin
            j_in = j_ff + CW'(1);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in  = {req_data.x ^ 16'h8000, req_data.y ^ 16'h8000};
               last_in = req_data.last;
               pos_in  = count_ff;
               if (count_ff >= CW'(MAX_POINTS)) begin
                  dropped_in = 1'b1;
                  state_in   = ST_CHECK;
               end else if (count_ff == '0) begin
                  state_in = ST_INS_PUT;
               end else begin
                  state_in = ST_INS_RD;
               end
            end
         end
         ST_INS_RD: begin
            state_in = ST_INS_CMP;
         end
         ST_INS_CMP: begin
            mem_we = 1'b1;
            if (ins_gt) begin
               // shift the larger key up one place
               mem_wdata = mem_qb;
               pos_in    = pos_ff - CW'(1);
               if (pos_ff == CW'(1)) begin
                  state_in = ST_INS_PUT;
               end
            end else begin
               count_in = count_ff + CW'(1);
               state_in = ST_CHECK;
            end
         end
         ST_INS_PUT: begin
            mem_we   = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            i_in = '0;
            j_in = CW'(1);
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (count_ff < CW'(2)) begin
               rsp_in           = '0;
               rsp_in.final_res = 1'b1;
               rsp_in.status    = cpp_pkg::STATUS_FEW;
               rsp_valid_in     = 1'b1;
               state_in         = ST_OUT_WAIT;
            end else begin
               state_in = ST_MIN;
            end
         end
         ST_MIN: begin
            if (dist_valid && pair_dist < best_ff) begin
               best_in = pair_dist;
            end
            if (!iss && !pipe_busy) begin
               i_in         = '0;
               j_in         = CW'(1);
               n_in         = '0;
               trunc_in     = 1'b0;
               have_prev_in = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (hit && !dup && !trunc_ff) begin
               if (n_ff == NW'(MAX_PAIRS)) begin
                  trunc_in = 1'b1;
               end else begin
                  n_in         = n_ff + NW'(1);
                  prev_in      = dist_pair;
                  have_prev_in = 1'b1;
               end
            end
            if (!iss && !pipe_busy) begin
               k_in     = '0;
               state_in = ST_OUT_RD;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            rsp_in.first_x          = $signed(buf_q.a[31:16] ^ 16'h8000);
            rsp_in.first_y          = $signed(buf_q.a[15:0] ^ 16'h8000);
            rsp_in.second_x         = $signed(buf_q.b[31:16] ^ 16'h8000);
            rsp_in.second_y         = $signed(buf_q.b[15:0] ^ 16'h8000);
            rsp_in.squared_distance = best_ff;
            rsp_in.final_res        = (k_ff + NW'(1) == n_ff);
            rsp_in.status           = set_status;
            rsp_valid_in            = 1'b1;
            state_in                = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.final_res) begin
                  count_in   = '0;
                  best_in    = {DW{1'b1}};
                  dropped_in = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  k_in     = k_ff + NW'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         best_ff      <= {DW{1'b1}};
         dropped_ff   <= 1'b0;
         trunc_ff     <= 1'b0;
         n_ff         <= '0;
         k_ff         <= '0;
         have_prev_ff <= 1'b0;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         best_ff      <= best_in;
         dropped_ff   <= dropped_in;
         trunc_ff     <= trunc_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         have_prev_ff <= have_prev_in;
         v1_ff        <= iss;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
      end
      key_ff  <= key_in;
      last_ff <= last_in;
      prev_ff <= prev_in;
      rsp_ff  <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("point count beyond capacity");

   a_pairs_range: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NW'(MAX_PAIRS))
      else $error("pair count beyond limit");

   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_OUT_WAIT))
      else $error("result shown outside the output wait state");

   a_no_issue_trunc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && trunc_ff) |=> !v1_ff)
      else $error("pair read issued after truncation");
`endif

endmodule

>>> rtl/cpp_point_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_point_mem
// Point store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module cpp_point_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                    clock,
   input  logic                    we,
   input  logic [AW-1:0]           waddr,
   input  logic [cpp_pkg::KEY_W-1:0] wdata,
   input  logic [AW-1:0]           ra_addr,
   input  logic [AW-1:0]           rb_addr,
   output logic [cpp_pkg::KEY_W-1:0] qa,
   output logic [cpp_pkg::KEY_W-1:0] qb
);

   logic [cpp_pkg::KEY_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      qa <= mem[ra_addr];
      qb <= mem[rb_addr];
   end

endmodule

>>> rtl/cpp_result_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_result_buf
// Holds the closest pairs of a set until the status is known.
// ----------------------------------------------------------------------------
module cpp_result_buf #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     waddr,
   input  cpp_pkg::pair_type wdata,
   input  logic [AW-1:0]     raddr,
   output cpp_pkg::pair_type q
);

   cpp_pkg::pair_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      q <= mem[raddr];
   end

endmodule

>>> rtl/cpp_dist_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_dist_unit
// Squared distance of a key pair; squares registered, sum at the output.
// ----------------------------------------------------------------------------
module cpp_dist_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  cpp_pkg::pair_type          in_pair,
   output logic                       out_valid,
   output cpp_pkg::pair_type          out_pair,
   output logic [cpp_pkg::DIST_W-1:0] out_dist
);

   logic signed [16:0]             dx, dy;
   logic signed [33:0]             px, py;
   logic [cpp_pkg::SQ_W-1:0]       sx_ff, sy_ff;
   logic                           valid_ff;
   cpp_pkg::pair_type              pair_ff;

   // offset keys keep the signed difference
   assign dx = $signed({1'b0, in_pair.a[31:16]}) - $signed({1'b0, in_pair.b[31:16]});
   assign dy = $signed({1'b0, in_pair.a[15:0]}) - $signed({1'b0, in_pair.b[15:0]});
   assign px = dx * dx;
   assign py = dy * dy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      sx_ff   <= px[cpp_pkg::SQ_W-1:0];
      sy_ff   <= py[cpp_pkg::SQ_W-1:0];
      pair_ff <= in_pair;
   end

   assign out_valid = valid_ff;
   assign out_pair  = pair_ff;
   assign out_dist  = {1'b0, sx_ff} + {1'b0, sy_ff};

endmodule
